// ===== rtl/terminal_line_assembler_defines.svh =====
// Assertion macros used by the line assembler control RTL.
`ifndef TERMINAL_LINE_ASSEMBLER_DEFINES_SVH
`define TERMINAL_LINE_ASSEMBLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line assembler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line assembler check failed");

`endif

// ===== rtl/tla_pkg.sv =====
// Shared types and constants of the terminal line assembler.
`default_nettype none

package tla_pkg;

    localparam int LINE_CAPACITY_DEF = 256;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_ECHO_ENABLE = 1'b0;
    localparam logic REG_ECHO_HIDDEN = 1'b1;

    localparam logic CMD_RECEIVE = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [7:0] BS_CODE    = 8'd8;
    localparam logic [7:0] DEL_CODE   = 8'd127;
    localparam logic [7:0] SPACE_CODE = 8'd32;
    localparam logic [7:0] NL_CODE    = 8'd10;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic [7:0] read_index;
    } req_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [7:0] line_length;
        logic       last;
    } rsp_item_t;

    typedef struct packed {
        logic echo_enable;
        logic echo_hidden;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/terminal_line_assembler.sv =====
// Top level of the terminal line assembler: registers, control and line store.
//
// Usage:
//   The req channel carries one beat per command: cmd receive takes
//   data_byte, cmd read returns the stored byte at read_index. The rsp
//   channel returns results in order; last marks the final result of a beat.
//   A delete echoes backspace, space, backspace; a control byte or a full
//   line ends the line with an optional newline echo and a line report.
// Flow:
//   The first result of a beat passes through the sequencing stage and
//   then the output register.
//   One beat with at most one result enters every cycle while rsp_ready
//   is high; a beat with more results holds the sequencing stage until its
//   last one is emitted. A line that ends on a full store blocks the next
//   beat while its terminating zero goes through the single store write port.
// Reset:
//   rst_n clears the write position, the sequencing stage and the output
//   register; echo is on and not hidden. The line store is not cleared.
// Stall:
//   While rsp_ready is low the output register holds its beat, the
//   sequencing stage holds the next result, and req_ready drops once that
//   stage is full.
`default_nettype none

module terminal_line_assembler #(
    parameter int LINE_CAPACITY = tla_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output      logic                            req_ready,
    input  wire tla_pkg::req_item_t              req,
    output      logic                            rsp_valid,
    input  wire logic                            rsp_ready,
    output      tla_pkg::rsp_item_t              rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tla_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tla_pkg::APB_DATA_W-1:0]  pwdata,
    output      logic [tla_pkg::APB_DATA_W-1:0]  prdata,
    output      logic                            pready
);
    import tla_pkg::*;

    localparam int PW = $clog2(LINE_CAPACITY);

    cfg_t          cfg;
    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [PW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    // Configuration registers: the user writes them only while the block is idle; the block does not enforce this.
    tla_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Decode beats, update the position, sequence results into the output register.
    tla_ctrl #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Line store; reads and writes never share a cycle, so no forwarding path.
    tla_store #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/tla_store.sv =====
// Line store: one write port, one read port with registered read data.
`default_nettype none

module tla_store #(
    parameter int LINE_CAPACITY = tla_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(LINE_CAPACITY)-1:0] waddr,
    input  wire logic [7:0]                       wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(LINE_CAPACITY)-1:0] raddr,
    output      logic [7:0]                       rdata
);
    import tla_pkg::*;

    logic [7:0] mem [LINE_CAPACITY];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/tla_regs.sv =====
// APB configuration registers: echo enable and hidden echo.
`default_nettype none

module tla_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tla_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [tla_pkg::APB_DATA_W-1:0]      pwdata,
    output      logic [tla_pkg::APB_DATA_W-1:0]      prdata,
    output      logic                                pready,
    output      tla_pkg::cfg_t                       cfg
);
    import tla_pkg::*;

    logic echo_enable_reg;
    logic echo_hidden_reg;
    logic wr_en;
    logic sel_reg_bit;

    assign wr_en       = psel && penable && pwrite;
    assign sel_reg_bit = paddr[2];
    assign pready      = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_enable_reg <= 1'b1;
            echo_hidden_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (sel_reg_bit)
                REG_ECHO_ENABLE: echo_enable_reg <= pwdata[0];
                REG_ECHO_HIDDEN: echo_hidden_reg <= pwdata[0];
                default:         echo_enable_reg <= echo_enable_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (sel_reg_bit)
            REG_ECHO_ENABLE: prdata[0] = echo_enable_reg;
            REG_ECHO_HIDDEN: prdata[0] = echo_hidden_reg;
            default:         prdata    = '0;
        endcase
    end

    assign cfg.echo_enable = echo_enable_reg;
    assign cfg.echo_hidden = echo_hidden_reg;

endmodule

`default_nettype wire

// ===== rtl/tla_ctrl.sv =====
// Line editing control: decode, store update, result sequencing, output register.
`default_nettype none
`include "terminal_line_assembler_defines.svh"

module tla_ctrl #(
    parameter int LINE_CAPACITY = tla_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tla_pkg::cfg_t                    cfg,
    input  wire logic                             req_valid,
    output      logic                             req_ready,
    input  wire tla_pkg::req_item_t               req,
    output      logic                             rsp_valid,
    input  wire logic                             rsp_ready,
    output      tla_pkg::rsp_item_t               rsp,
    output      logic                             mem_we,
    output      logic [$clog2(LINE_CAPACITY)-1:0] mem_waddr,
    output      logic [7:0]                       mem_wdata,
    output      logic                             mem_re,
    output      logic [$clog2(LINE_CAPACITY)-1:0] mem_raddr,
    input  wire logic [7:0]                       mem_rdata
);
    import tla_pkg::*;

    localparam int PW = $clog2(LINE_CAPACITY);
    localparam int AW = (PW > 8) ? PW : 8;

    // Result groups held in the sequencing stage.
    localparam logic [1:0] GRP_READ = 2'd0;
    localparam logic [1:0] GRP_DEL  = 2'd1;
    localparam logic [1:0] GRP_ECHO = 2'd2;
    localparam logic [1:0] GRP_LINE = 2'd3;

    logic [PW-1:0] pos_reg, pos_next;
    logic          zw_pending_reg, zw_pending_next;
    logic [PW-1:0] zw_addr_reg;

    logic          s1_valid_reg;
    logic [1:0]    s1_grp_reg;
    logic [7:0]    s1_val_reg;
    logic [7:0]    s1_len_reg;
    logic          s1_echo_reg;
    logic          s1_inrange_reg;
    logic [1:0]    s1_cur_reg;

    logic          rsp_valid_reg;
    rsp_item_t     rsp_reg;

    logic          accept;
    logic          is_read, is_del, is_ctl, is_full;
    logic [PW-1:0] pos_plus1;
    logic [AW-1:0] pos_ext, pos1_ext, ridx_ext;
    logic          ridx_inrange;

    logic          load_grp;
    logic [1:0]    grp_new;
    logic [7:0]    val_new;
    logic [7:0]    len_new;

    logic          emit;
    logic          s1_done;
    rsp_item_t     cur_item;

    assign accept    = req_valid && req_ready;
    assign is_read   = (req.cmd == CMD_READ);
    assign is_del    = (req.data_byte == BS_CODE) || (req.data_byte == DEL_CODE);
    assign is_ctl    = (req.data_byte < SPACE_CODE) && !is_del;
    assign is_full   = (32'(pos_reg) + 32'd2) == 32'(LINE_CAPACITY);
    assign pos_plus1 = pos_reg + PW'(1);
    assign pos_ext   = AW'(pos_reg);
    assign pos1_ext  = AW'(pos_plus1);
    assign ridx_ext  = AW'(req.read_index);
    assign ridx_inrange = 32'(req.read_index) < 32'(LINE_CAPACITY);

    assign mem_raddr = ridx_ext[PW-1:0];

    // Decode the accepted beat into a store update and a result group.
    always_comb
    begin
        pos_next        = pos_reg;
        zw_pending_next = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = req.data_byte;
        mem_re          = 1'b0;
        load_grp        = 1'b0;
        grp_new         = GRP_READ;
        val_new         = req.data_byte;
        len_new         = 8'd0;

        if (zw_pending_reg)
        begin
            // Second write of a full line: terminating zero after the last byte.
            mem_we    = 1'b1;
            mem_waddr = zw_addr_reg;
            mem_wdata = 8'd0;
        end
        else if (accept)
        begin
            if (is_read)
            begin
                mem_re   = 1'b1;
                load_grp = 1'b1;
                grp_new  = GRP_READ;
            end
            else if (is_del)
            begin
                if (pos_reg != '0)
                begin
                    pos_next = pos_reg - PW'(1);
                    load_grp = cfg.echo_enable;
                    grp_new  = GRP_DEL;
                end
            end
            else if (is_ctl)
            begin
                mem_we    = 1'b1;
                mem_wdata = 8'd0;
                pos_next  = '0;
                load_grp  = 1'b1;
                grp_new   = GRP_LINE;
                len_new   = pos_ext[7:0];
            end
            else
            begin
                mem_we = 1'b1;
                if (is_full)
                begin
                    zw_pending_next = 1'b1;
                    pos_next        = '0;
                    load_grp        = 1'b1;
                    grp_new         = GRP_LINE;
                    val_new         = 8'd0;
                    len_new         = pos1_ext[7:0];
                end
                else
                begin
                    pos_next = pos_plus1;
                    load_grp = cfg.echo_enable && !cfg.echo_hidden;
                    grp_new  = GRP_ECHO;
                end
            end
        end
    end

    // Current result of the held group.
    always_comb
    begin
        cur_item = '0;
        unique case (s1_grp_reg)
            GRP_READ:
            begin
                cur_item.kind  = KIND_READ;
                cur_item.value = s1_inrange_reg ? mem_rdata : 8'd0;
                cur_item.last  = 1'b1;
            end
            GRP_DEL:
            begin
                cur_item.kind  = KIND_ECHO;
                cur_item.value = (s1_cur_reg == 2'd1) ? SPACE_CODE : BS_CODE;
                cur_item.last  = (s1_cur_reg == 2'd2);
            end
            GRP_ECHO:
            begin
                cur_item.kind  = KIND_ECHO;
                cur_item.value = s1_val_reg;
                cur_item.last  = 1'b1;
            end
            GRP_LINE:
            begin
                if (s1_echo_reg && (s1_cur_reg == 2'd0))
                begin
                    cur_item.kind  = KIND_ECHO;
                    cur_item.value = NL_CODE;
                end
                else
                begin
                    cur_item.kind        = KIND_LINE;
                    cur_item.value       = s1_val_reg;
                    cur_item.line_length = s1_len_reg;
                    cur_item.last        = 1'b1;
                end
            end
            default: cur_item = '0;
        endcase
    end

    assign emit      = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign s1_done   = emit && cur_item.last;
    assign req_ready = !zw_pending_reg && (!s1_valid_reg || s1_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            zw_pending_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s1_cur_reg     <= 2'd0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            zw_pending_reg <= zw_pending_next;

            if (load_grp)
            begin
                s1_valid_reg <= 1'b1;
                s1_cur_reg   <= 2'd0;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                s1_cur_reg <= s1_cur_reg + 2'd1;
            end

            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            zw_addr_reg <= pos_plus1;
        end
        if (load_grp)
        begin
            s1_grp_reg     <= grp_new;
            s1_val_reg     <= val_new;
            s1_len_reg     <= len_new;
            s1_echo_reg    <= cfg.echo_enable;
            s1_inrange_reg <= ridx_inrange;
        end
        if (emit)
        begin
            rsp_reg <= cur_item;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `TLA_ASSERT_NOW(a_zero_write_blocks_input, clk, rst_n, zw_pending_reg, !req_ready)
    `TLA_ASSERT_NOW(a_position_bound, clk, rst_n, 1'b1, (32'(pos_reg) + 32'd2) <= 32'(LINE_CAPACITY))
    `TLA_ASSERT_NEXT(a_full_line_zero_write, clk, rst_n, accept && !is_read && !is_del && !is_ctl && is_full, zw_pending_reg && (pos_reg == '0))
    `TLA_ASSERT_NOW(a_load_only_when_free, clk, rst_n, load_grp, !s1_valid_reg || s1_done)

endmodule

`default_nettype wire

// ===== dv/terminal_line_assembler_test.sv =====
// Self-checking testbench of the terminal line assembler: directed rows, then random lines.
module terminal_line_assembler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tla_pkg::*;

    localparam int LINE_CAP        = LINE_CAPACITY_DEF;
    localparam int SETTLE_CYCLES   = 12;    // output latency plus the extra store write
    localparam int HOLD_OFF_CYCLES = 64;    // long receiver stall used to back up the block
    localparam int QUIET_LIMIT     = 2000;  // cycles with no beat on either channel
    localparam int PHASE_BEATS     = 30;
    localparam int PHASES          = 6;
    localparam int DIR_ROWS        = 25;

    localparam logic [APB_ADDR_W-1:0] ADDR_ECHO_ENABLE = APB_ADDR_W'(4 * REG_ECHO_ENABLE);
    localparam logic [APB_ADDR_W-1:0] ADDR_ECHO_HIDDEN = APB_ADDR_W'(4 * REG_ECHO_HIDDEN);

    // Echo setting and idle mode of each random phase. Mode 0: sender idles 25 %,
    // receiver 48 %; mode 1: the other way round; mode 2: nobody idles.
    localparam int PH_ECHO_ON  [PHASES] = '{1, 1, 1, 0, 0, 1};
    localparam int PH_ECHO_HID [PHASES] = '{0, 1, 0, 0, 1, 1};
    localparam int PH_MODE     [PHASES] = '{0, 1, 2, 0, 1, 2};

    // One directed row: the beat, and where typed is set, the results written out.
    typedef struct packed {
        logic       typed;
        logic [1:0] count;
        rsp_item_t  r0;
        rsp_item_t  r1;
        rsp_item_t  r2;
        req_item_t  item;
    } dir_row_t;

    localparam rsp_item_t NO_RSP = '0;
    localparam rsp_item_t R_NL   = '{KIND_ECHO, NL_CODE, 8'd0, 1'b0};
    localparam rsp_item_t R_BS0  = '{KIND_ECHO, BS_CODE, 8'd0, 1'b0};
    localparam rsp_item_t R_SP   = '{KIND_ECHO, SPACE_CODE, 8'd0, 1'b0};
    localparam rsp_item_t R_BS1  = '{KIND_ECHO, BS_CODE, 8'd0, 1'b1};

    // Reset echo settings are in force here: echo on, not hidden.
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // deletes on an empty line do nothing
        '{1'b1, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_RECEIVE, BS_CODE, 8'h00}},
        '{1'b1, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_RECEIVE, DEL_CODE, 8'hFF}},
        // NUL closes an empty line
        '{1'b1, 2'd2, R_NL, '{KIND_LINE, 8'h00, 8'd0, 1'b1}, NO_RSP,
          '{CMD_RECEIVE, 8'h00, 8'h00}},
        '{1'b1, 2'd1, '{KIND_READ, 8'h00, 8'd0, 1'b1}, NO_RSP, NO_RSP,
          '{CMD_READ, 8'hFF, 8'h00}},
        // printable edges: space, tilde, first and last high byte
        '{1'b1, 2'd1, '{KIND_ECHO, 8'h20, 8'd0, 1'b1}, NO_RSP, NO_RSP,
          '{CMD_RECEIVE, 8'h20, 8'h55}},
        '{1'b1, 2'd1, '{KIND_ECHO, 8'h7E, 8'd0, 1'b1}, NO_RSP, NO_RSP,
          '{CMD_RECEIVE, 8'h7E, 8'hAA}},
        '{1'b1, 2'd1, '{KIND_ECHO, 8'h80, 8'd0, 1'b1}, NO_RSP, NO_RSP,
          '{CMD_RECEIVE, 8'h80, 8'h00}},
        '{1'b1, 2'd1, '{KIND_ECHO, 8'hFF, 8'd0, 1'b1}, NO_RSP, NO_RSP,
          '{CMD_RECEIVE, 8'hFF, 8'hFF}},
        // both delete codes with something to delete
        '{1'b1, 2'd3, R_BS0, R_SP, R_BS1, '{CMD_RECEIVE, DEL_CODE, 8'h00}},
        '{1'b1, 2'd3, R_BS0, R_SP, R_BS1, '{CMD_RECEIVE, BS_CODE, 8'h00}},
        '{1'b1, 2'd1, '{KIND_READ, 8'h7E, 8'd0, 1'b1}, NO_RSP, NO_RSP,
          '{CMD_READ, 8'h00, 8'h01}},
        // a deleted byte still sits in the store
        '{1'b0, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_READ, 8'h00, 8'h03}},
        '{1'b0, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_RECEIVE, 8'h41, 8'h00}},
        // highest control byte closes a three byte line
        '{1'b1, 2'd2, R_NL, '{KIND_LINE, 8'h1F, 8'd3, 1'b1}, NO_RSP,
          '{CMD_RECEIVE, 8'h1F, 8'h00}},
        '{1'b0, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_RECEIVE, 8'h0D, 8'h00}},
        '{1'b0, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_RECEIVE, 8'h09, 8'h00}},
        '{1'b0, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_RECEIVE, 8'h68, 8'h00}},
        '{1'b0, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_RECEIVE, 8'h69, 8'h00}},
        '{1'b0, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_RECEIVE, DEL_CODE, 8'h00}},
        '{1'b0, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_RECEIVE, 8'h0A, 8'h00}},
        '{1'b0, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_READ, 8'h00, 8'h02}},
        '{1'b0, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_READ, 8'h00, 8'h00}},
        '{1'b0, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_RECEIVE, 8'h1B, 8'h00}},
        '{1'b0, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_RECEIVE, 8'h01, 8'h00}},
        '{1'b0, 2'd0, NO_RSP, NO_RSP, NO_RSP, '{CMD_RECEIVE, 8'h5A, 8'h00}}
    };

    // Block ports. Every input starts at a known value.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_item_t             req_beat  = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_item_t             rsp_beat;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow of the line editor: store, position and echo settings.
    logic [7:0] line_mem [LINE_CAP];
    int         line_pos   = 0;
    int         stored_top = -1;    // entries 0..stored_top have been written
    logic       echo_on    = 1'b1;
    logic       echo_hid   = 1'b0;

    rsp_item_t  awaited_results [$];

    int errors        = 0;
    int beats_in      = 0;
    int beats_out     = 0;
    int lines_done    = 0;
    int full_ends     = 0;
    int deletes_done  = 0;
    int reads_done    = 0;
    int src_gap_pct   = 0;
    int sink_gap_pct  = 0;
    int stall_asks    = 0;
    int quiet_cycles  = 0;

    terminal_line_assembler #(
        .LINE_CAPACITY (LINE_CAP)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_beat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_beat),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Work out the results of one accepted beat and advance the shadow state.
    function automatic int predict_line_edit(input req_item_t it, output rsp_item_t [2:0] res);
        int         p;
        int         n;
        int         len;
        logic [7:0] term;
        p   = line_pos;
        n   = 0;
        res = '0;
        if (it.cmd == CMD_READ)
        begin
            reads_done++;
            res[0] = '{KIND_READ, (int'(it.read_index) < LINE_CAP) ? line_mem[it.read_index]
                                                                   : 8'h00, 8'd0, 1'b1};
            return 1;
        end
        if (it.data_byte == BS_CODE || it.data_byte == DEL_CODE)
        begin
            // nothing to erase: the byte is dropped silently
            if (p == 0)
                return 0;
            line_pos = p - 1;
            deletes_done++;
            if (!echo_on)
                return 0;
            res[0] = R_BS0;
            res[1] = R_SP;
            res[2] = R_BS1;
            return 3;
        end
        if (it.data_byte < SPACE_CODE)
        begin
            // control byte: close the line, store a terminating zero
            line_mem[p] = 8'h00;
            if (p > stored_top)
                stored_top = p;
            term = it.data_byte;
            len  = p;
        end
        else
        begin
            line_mem[p] = it.data_byte;
            if (p > stored_top)
                stored_top = p;
            if (p + 2 != LINE_CAP)
            begin
                line_pos = p + 1;
                if (echo_on && !echo_hid)
                begin
                    res[0] = '{KIND_ECHO, it.data_byte, 8'd0, 1'b1};
                    return 1;
                end
                return 0;
            end
            // store full: the byte joins the line unechoed, and the line closes
            line_mem[p + 1] = 8'h00;
            if (p + 1 > stored_top)
                stored_top = p + 1;
            term = 8'h00;
            len  = p + 1;
            full_ends++;
        end
        if (echo_on)
        begin
            res[n] = R_NL;
            n++;
        end
        res[n] = '{KIND_LINE, term, 8'(len), 1'b1};
        n++;
        line_pos = 0;
        lines_done++;
        return n;
    endfunction

    // Offer one request beat; return at the edge that accepts it.
    task automatic push_req(input req_item_t it);
        while (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_beat  <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        beats_in++;
    endtask

    // Send a beat and queue the predicted results.
    task automatic send_beat(input req_item_t it);
        rsp_item_t [2:0] res;
        int              n;
        push_req(it);
        n = predict_line_edit(it, res);
        for (int k = 0; k < n; k++)
            awaited_results.push_back(res[k]);
    endtask

    // Drop valid, wait for every awaited result, then let the pipe go quiet.
    task automatic settle();
        req_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access cycle, then back to idle.
    task automatic apb_cycle(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] wdata,
                             output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input string name, input logic [APB_ADDR_W-1:0] addr,
                             input logic want);
        logic [APB_DATA_W-1:0] rd;
        apb_cycle(1'b0, addr, '0, rd);
        if (rd !== APB_DATA_W'(want))
        begin
            errors++;
            $display("%0t ns: %s readback mismatch, expected %0d, got %0d",
                     $time, name, want, rd);
        end
    endtask

    // Write both echo registers with junk in the upper bits, then read them back.
    task automatic set_echo(input logic en, input logic hid);
        logic [APB_DATA_W-1:0] wd;
        logic [APB_DATA_W-1:0] rd;
        wd    = $urandom();
        wd[0] = en;
        apb_cycle(1'b1, ADDR_ECHO_ENABLE, wd, rd);
        wd    = $urandom();
        wd[0] = hid;
        apb_cycle(1'b1, ADDR_ECHO_HIDDEN, wd, rd);
        echo_on  = en;
        echo_hid = hid;
        check_reg("echo_enable", ADDR_ECHO_ENABLE, en);
        check_reg("echo_hidden", ADDR_ECHO_HIDDEN, hid);
    endtask

    // Optionally fill the store first; then mostly well-formed lines with random content, some reads, some raw noise.
    task automatic run_phase(input bool_full, input bit stall);
        req_item_t it;
        int        start;
        int        len;
        int        roll;
        int        closed;
        bit        mid_done;
        start    = beats_in;
        mid_done = 1'b0;
        if (stall)
            stall_asks++;
        if (bool_full)
        begin
            // fill the store to the brim; the line closes on its own
            closed = full_ends;
            while (full_ends == closed)
            begin
                it.cmd        = CMD_RECEIVE;
                it.read_index = 8'($urandom());
                if ($urandom_range(0, 99) < 5)
                    it.data_byte = DEL_CODE;
                else
                    it.data_byte = 8'($urandom_range(32, 126));
                send_beat(it);
            end
            start = beats_in;
        end
        while (beats_in - start < PHASE_BEATS)
        begin
            if (stall && !mid_done && beats_in - start >= PHASE_BEATS / 2)
            begin
                mid_done = 1'b1;
                stall_asks++;
            end
            roll = $urandom_range(0, 99);
            if (roll < 65)
            begin
                len = $urandom_range(0, 12);
                it.cmd = CMD_RECEIVE;
                for (int k = 0; k < len; k++)
                begin
                    it.read_index = 8'($urandom());
                    if ($urandom_range(0, 99) < 15)
                        it.data_byte = $urandom_range(0, 1) ? BS_CODE : DEL_CODE;
                    else
                    begin
                        it.data_byte = 8'($urandom_range(32, 255));
                        if (it.data_byte == DEL_CODE)
                            it.data_byte = 8'h7E;
                    end
                    send_beat(it);
                end
                // close with a control byte other than backspace
                it.read_index = 8'($urandom());
                it.data_byte  = 8'($urandom_range(0, 31));
                if (it.data_byte == BS_CODE)
                    it.data_byte = 8'h0D;
                send_beat(it);
            end
            else if (roll < 85 && stored_top >= 0)
            begin
                it.cmd        = CMD_READ;
                it.data_byte  = 8'($urandom());
                it.read_index = 8'($urandom_range(0, stored_top));
                send_beat(it);
            end
            else
            begin
                it.cmd        = CMD_RECEIVE;
                it.data_byte  = 8'($urandom());
                it.read_index = 8'($urandom());
                send_beat(it);
            end
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Receiver: random ready, or a long hold-off when one is asked for.
    initial
    begin : sink_side
        int seen;
        int hold;
        seen = 0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (seen != stall_asks)
            begin
                seen = stall_asks;
                hold = HOLD_OFF_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(0, 99) >= sink_gap_pct);
        end
    end

    // Compare each result beat with the oldest one awaited.
    always @(posedge clk)
    begin : result_check
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            beats_out++;
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: result beat with none awaited, expected nothing, got %h",
                         $time, rsp_beat);
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("kind", want.kind, rsp_beat.kind);
                check_field("value", want.value, rsp_beat.value);
                check_field("line_length", want.line_length, rsp_beat.line_length);
                check_field("last", want.last, rsp_beat.last);
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t ns: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("terminal_line_assembler verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : main_flow
        dir_row_t        row;
        rsp_item_t [2:0] res;
        int              n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers must come out of reset with echo on, not hidden
        check_reg("echo_enable", ADDR_ECHO_ENABLE, 1'b1);
        check_reg("echo_hidden", ADDR_ECHO_HIDDEN, 1'b0);

        // directed rows under the reset settings
        src_gap_pct  = 25;
        sink_gap_pct = 48;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIRECTED[i];
            push_req(row.item);
            n = predict_line_edit(row.item, res);
            if (row.typed)
            begin
                if (row.count > 0)
                    awaited_results.push_back(row.r0);
                if (row.count > 1)
                    awaited_results.push_back(row.r1);
                if (row.count > 2)
                    awaited_results.push_back(row.r2);
            end
            else
            begin
                for (int k = 0; k < n; k++)
                    awaited_results.push_back(res[k]);
            end
        end
        settle();

        // random phases; each ends with the sender paused until all results are in
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_echo(PH_ECHO_ON[ph][0], PH_ECHO_HID[ph][0]);
            src_gap_pct  = (PH_MODE[ph] == 0) ? 25 : (PH_MODE[ph] == 1) ? 48 : 0;
            sink_gap_pct = (PH_MODE[ph] == 0) ? 48 : (PH_MODE[ph] == 1) ? 25 : 0;
            run_phase(ph == 0, PH_MODE[ph] == 2);
            settle();
        end

        $display("Sent %0d request beats (%0d directed), checked %0d result beats.",
                 beats_in, DIR_ROWS, beats_out);
        $display("Closed %0d lines (%0d on a full store), %0d deletes, %0d reads, %0d settings.",
                 lines_done, full_ends, deletes_done, reads_done, PHASES + 1);
        if (errors == 0)
            $display("terminal_line_assembler verification clean");
        else
            $display("terminal_line_assembler verification failed");
        $finish;
    end

endmodule
